FILE: hw/rtl/vmt_pkg.sv
// vmt_pkg: shared constants and types for the vector move-towards pipeline.
// Used by vmt_sqrt_cell, vmt_div_cell and vector_move_towards. No dependencies.
`default_nettype none

package vmt_pkg;

  // default fractional bits of the Q format
  localparam int unsigned FRAC_BITS_DEF = 16;
  // coordinate word width
  localparam int unsigned WORD_W = 32;
  // quotient bits produced by the divider chain; offsets stay below 2^33
  localparam int unsigned QUO_BITS = 34;

  // sideband that travels with every word through the cells
  typedef struct packed {
    logic                   bypass;  // result is the target itself
    logic [2:0]             neg;     // offset sign per component
    logic [2:0][WORD_W-1:0] base;    // target when bypassed, else current point
  } side_t;

endpackage

`default_nettype wire

FILE: hw/rtl/vmt_sqrt_cell.sv
// vmt_sqrt_cell: one digit step of the integer square root, one root bit per cell.
// Carries the word's sideband and numerators along. Depends on vmt_pkg.
`default_nettype none

module vmt_sqrt_cell #(
  parameter int unsigned NR = 49,  // root bits
  parameter int unsigned NW = 80   // numerator bits
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic                   valid_i,
  input  wire vmt_pkg::side_t         side_i,
  input  wire logic [2*NR-1:0]        x_i,
  input  wire logic [NR-1:0]          root_i,
  input  wire logic [NR+1:0]          rem_i,
  input  wire logic [2:0][NW-1:0]     num_i,
  output logic                        valid_o,
  output vmt_pkg::side_t              side_o,
  output logic [2*NR-1:0]             x_o,
  output logic [NR-1:0]               root_o,
  output logic [NR+1:0]               rem_o,
  output logic [2:0][NW-1:0]          num_o
);

  logic [NR+1:0] rem_sh, trial, rem_d;
  logic          ge;
  logic          valid_q;

  // bring down two radicand bits, trial subtract 4r+1
  always_comb begin
    rem_sh = {rem_i[NR-1:0], x_i[2*NR-1 -: 2]};
    trial  = {root_i, 2'b01};
    ge     = (rem_sh >= trial);
    rem_d  = ge ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_i;
      x_o    <= {x_i[2*NR-3:0], 2'b00};
      root_o <= {root_i[NR-2:0], ge};
      rem_o  <= rem_d;
      num_o  <= num_i;
    end
  end

  assign valid_o = valid_q;

endmodule

`default_nettype wire

FILE: hw/rtl/vmt_div_cell.sv
// vmt_div_cell: one restoring division step for three lanes sharing one divisor.
// Dividend bits shift out the top of sh, quotient bits shift in at the bottom.
// Depends on vmt_pkg.
`default_nettype none

module vmt_div_cell #(
  parameter int unsigned NR = 49,  // divisor bits
  parameter int unsigned QB = 34   // quotient bits
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire vmt_pkg::side_t       side_i,
  input  wire logic [NR-1:0]        lf_i,
  input  wire logic [2:0][NR:0]     rem_i,
  input  wire logic [2:0][QB-1:0]   sh_i,
  output logic                      valid_o,
  output vmt_pkg::side_t            side_o,
  output logic [NR-1:0]             lf_o,
  output logic [2:0][NR:0]          rem_o,
  output logic [2:0][QB-1:0]        sh_o
);

  logic [2:0][NR:0]   rem_sh, rem_d;
  logic [2:0][QB-1:0] sh_d;
  logic [2:0]         ge;
  logic               valid_q;

  // per lane: shift in next dividend bit, compare and subtract
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rem_sh[l] = {rem_i[l][NR-1:0], sh_i[l][QB-1]};
      ge[l]     = (rem_sh[l] >= {1'b0, lf_i});
      rem_d[l]  = ge[l] ? (rem_sh[l] - {1'b0, lf_i}) : rem_sh[l];
      sh_d[l]   = {sh_i[l][QB-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_i;
      lf_o   <= lf_i;
      rem_o  <= rem_d;
      sh_o   <= sh_d;
    end
  end

  assign valid_o = valid_q;

endmodule

`default_nettype wire

FILE: hw/rtl/vector_move_towards.sv
// vector_move_towards: pipelined fixed-point 3D move-towards step.
// Instantiates vmt_sqrt_cell and vmt_div_cell chains; depends on vmt_pkg.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  input    | valid_i / stall_o  | cur_x/y/z_i, tgt_x/y/z_i, step_dist_i
//  output   | valid_o / stall_i  | res_x/y/z_o, reached_o
//
// One word per cycle enters while stall_o is low; a word passes stages 1 to 3,
// the root chain (one cell per root bit), stage 4, the divider chain (one cell
// per quotient bit) and the registered output stage.
// Reset clears all valid flags; the pipeline holds no other state.
// The whole pipeline advances together; it freezes only while a result waits
// at the output and stall_i is high, and stall_o follows that condition.
`default_nettype none

module vector_move_towards #(
  parameter int unsigned FRAC_BITS = vmt_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [31:0] cur_x_i,
  input  wire logic [31:0] cur_y_i,
  input  wire logic [31:0] cur_z_i,
  input  wire logic [31:0] tgt_x_i,
  input  wire logic [31:0] tgt_y_i,
  input  wire logic [31:0] tgt_z_i,
  input  wire logic [31:0] step_dist_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [31:0]      res_x_o,
  output logic [31:0]      res_y_o,
  output logic [31:0]      res_z_o,
  output logic             reached_o
);

  localparam int unsigned NR = 33 + FRAC_BITS;      // root bits
  localparam int unsigned XW = 2 * NR;              // radicand bits
  localparam int unsigned NW = 64 + FRAC_BITS;      // numerator bits
  localparam int unsigned QB = vmt_pkg::QUO_BITS;   // quotient bits
  localparam int unsigned W  = vmt_pkg::WORD_W;

  logic en;

  // global advance: hold everything while the output word is blocked
  assign en      = !(valid_o && stall_i);
  assign stall_o = valid_o && stall_i;

  // ---------------- stage 1: differences and magnitudes
  logic [2:0][W-1:0] cur_in, tgt_in, dabs_d;
  logic [2:0]        dneg_d;
  logic [2:0][W:0]   diff, ndiff;
  logic [W-1:0]      sabs_d, nstep;
  logic              v1_q, sneg1_q, spos1_q;
  logic [2:0][W-1:0] cur1_q, tgt1_q, dabs1_q;
  logic [2:0]        dneg1_q;
  logic [W-1:0]      sabs1_q;

  always_comb begin
    cur_in = {cur_z_i, cur_y_i, cur_x_i};
    tgt_in = {tgt_z_i, tgt_y_i, tgt_x_i};
    for (int i = 0; i < 3; i++) begin
      diff[i]   = {tgt_in[i][W-1], tgt_in[i]} - {cur_in[i][W-1], cur_in[i]};
      ndiff[i]  = -diff[i];
      dneg_d[i] = diff[i][W];
      dabs_d[i] = dneg_d[i] ? ndiff[i][W-1:0] : diff[i][W-1:0];
    end
    nstep  = -step_dist_i;
    sabs_d = step_dist_i[W-1] ? nstep : step_dist_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cur1_q  <= cur_in;
      tgt1_q  <= tgt_in;
      dabs1_q <= dabs_d;
      dneg1_q <= dneg_d;
      sabs1_q <= sabs_d;
      sneg1_q <= step_dist_i[W-1];
      spos1_q <= !step_dist_i[W-1] && (step_dist_i != '0);
    end
  end

  // ---------------- stage 2: squares and distance products
  logic              v2_q, spos2_q;
  logic [2:0][63:0]  sq2_q, prod2_q;
  logic [63:0]       ssq2_q;
  logic [2:0][W-1:0] cur2_q, tgt2_q;
  logic [2:0]        neg2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq2_q[i]   <= 64'(dabs1_q[i]) * 64'(dabs1_q[i]);
        prod2_q[i] <= 64'(dabs1_q[i]) * 64'(sabs1_q);
      end
      ssq2_q  <= 64'(sabs1_q) * 64'(sabs1_q);
      spos2_q <= spos1_q;
      cur2_q  <= cur1_q;
      tgt2_q  <= tgt1_q;
      neg2_q  <= dneg1_q ^ {3{sneg1_q}};
    end
  end

  // ---------------- stage 3: squared length, zero-length and overshoot test
  logic [65:0]         l2;
  logic                bypass3;
  logic                v3_q;
  vmt_pkg::side_t      side3_q;
  logic [XW-1:0]       x3_q;
  logic [2:0][NW-1:0]  num3_q;

  always_comb begin
    l2      = {2'b00, sq2_q[0]} + {2'b00, sq2_q[1]} + {2'b00, sq2_q[2]};
    bypass3 = (l2 == '0) || (spos2_q && (l2 < {2'b00, ssq2_q}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side3_q.bypass <= bypass3;
      side3_q.neg    <= neg2_q;
      side3_q.base   <= bypass3 ? tgt2_q : cur2_q;
      x3_q           <= {l2, {(2*FRAC_BITS){1'b0}}};
      for (int i = 0; i < 3; i++) begin
        num3_q[i] <= {prod2_q[i], {FRAC_BITS{1'b0}}};
      end
    end
  end

  // ---------------- root chain: one cell per root bit
  logic               sv    [NR+1];
  vmt_pkg::side_t     sside [NR+1];
  logic [XW-1:0]      sx    [NR+1];
  logic [NR-1:0]      sroot [NR+1];
  logic [NR+1:0]      srem  [NR+1];
  logic [2:0][NW-1:0] snum  [NR+1];

  assign sv[0]    = v3_q;
  assign sside[0] = side3_q;
  assign sx[0]    = x3_q;
  assign sroot[0] = '0;
  assign srem[0]  = '0;
  assign snum[0]  = num3_q;

  for (genvar k = 0; k < NR; k++) begin : g_sqrt
    vmt_sqrt_cell #(.NR(NR), .NW(NW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sv[k]),
      .side_i  (sside[k]),
      .x_i     (sx[k]),
      .root_i  (sroot[k]),
      .rem_i   (srem[k]),
      .num_i   (snum[k]),
      .valid_o (sv[k+1]),
      .side_o  (sside[k+1]),
      .x_o     (sx[k+1]),
      .root_o  (sroot[k+1]),
      .rem_o   (srem[k+1]),
      .num_o   (snum[k+1])
    );
  end

  // ---------------- stage 4: add half divisor for rounding, split dividend
  logic [2:0][NW-1:0] numh;
  logic               v4_q;
  vmt_pkg::side_t     side4_q;
  logic [NR-1:0]      lf4_q;
  logic [2:0][NR:0]   rem4_q;
  logic [2:0][QB-1:0] sh4_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      numh[i] = snum[NR][i] + NW'(sroot[NR] >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= sv[NR];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side4_q <= sside[NR];
      lf4_q   <= sroot[NR];
      for (int i = 0; i < 3; i++) begin
        rem4_q[i] <= {{(NR+1-(NW-QB)){1'b0}}, numh[i][NW-1:QB]};
        sh4_q[i]  <= numh[i][QB-1:0];
      end
    end
  end

  // ---------------- divider chain: one cell per quotient bit
  logic               dv    [QB+1];
  vmt_pkg::side_t     dside [QB+1];
  logic [NR-1:0]      dlf   [QB+1];
  logic [2:0][NR:0]   drem  [QB+1];
  logic [2:0][QB-1:0] dsh   [QB+1];

  assign dv[0]    = v4_q;
  assign dside[0] = side4_q;
  assign dlf[0]   = lf4_q;
  assign drem[0]  = rem4_q;
  assign dsh[0]   = sh4_q;

  for (genvar k = 0; k < QB; k++) begin : g_div
    vmt_div_cell #(.NR(NR), .QB(QB)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv[k]),
      .side_i  (dside[k]),
      .lf_i    (dlf[k]),
      .rem_i   (drem[k]),
      .sh_i    (dsh[k]),
      .valid_o (dv[k+1]),
      .side_o  (dside[k+1]),
      .lf_o    (dlf[k+1]),
      .rem_o   (drem[k+1]),
      .sh_o    (dsh[k+1])
    );
  end

  // ---------------- output stage: signed offset, add, saturate, or the target on bypass
  logic [2:0][35:0]  qe, offs, sum;
  logic [2:0][W-1:0] res_d;
  logic              vo_q;
  logic [2:0][W-1:0] res_q;
  logic              reached_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qe[i]   = {2'b00, dsh[QB][i]};
      offs[i] = dside[QB].neg[i] ? -qe[i] : qe[i];
      sum[i]  = {{4{dside[QB].base[i][W-1]}}, dside[QB].base[i]} + offs[i];
      if (dside[QB].bypass) begin
        res_d[i] = dside[QB].base[i];
      end else if (sum[i][35:31] == 5'b00000 || sum[i][35:31] == 5'b11111) begin
        res_d[i] = sum[i][W-1:0];
      end else if (sum[i][35]) begin
        res_d[i] = {1'b1, {(W-1){1'b0}}};
      end else begin
        res_d[i] = {1'b0, {(W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en) begin
      vo_q <= dv[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q     <= res_d;
      reached_q <= dside[QB].bypass;
    end
  end

  assign valid_o   = vo_q;
  assign res_x_o   = res_q[0];
  assign res_y_o   = res_q[1];
  assign res_z_o   = res_q[2];
  assign reached_o = reached_q;

`ifndef SYNTHESIS
  // input is held back only while a finished word is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i))
    else $error("stall_o without a blocked output word");

  // divider never sees a zero length on a word that uses the quotient
  a_nonzero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !side4_q.bypass) |-> (lf4_q != '0))
    else $error("zero length reached the divider");

  // output drains when taken and nothing follows
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !stall_i && !dv[QB]) |=> !valid_o)
    else $error("output word repeated");

  // a word leaving the divider chain shows up at the output next cycle
  a_deliver: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv[QB] && en) |=> valid_o)
    else $error("word lost at output stage");
`endif

endmodule

`default_nettype wire

FILE: tb/vmt_checker.sv
// vmt_checker: watches both channels of vector_move_towards, predicts each result
// from the accepted input word and compares it. Depends on nothing but its ports.
`default_nettype none

module vmt_checker #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic [31:0] cur_x_i,
  input  wire logic [31:0] cur_y_i,
  input  wire logic [31:0] cur_z_i,
  input  wire logic [31:0] tgt_x_i,
  input  wire logic [31:0] tgt_y_i,
  input  wire logic [31:0] tgt_z_i,
  input  wire logic [31:0] step_dist_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic [31:0] res_x_i,
  input  wire logic [31:0] res_y_i,
  input  wire logic [31:0] res_z_i,
  input  wire logic        reached_i,
  output int               errors_o,
  output int               pending_o,
  output int               results_o,
  output int               reached_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        reached;
  } point_t;

  point_t moved_q[$];

  // integer square root of a wide unsigned value
  function automatic logic [63:0] isqrt128(logic [127:0] v);
    logic [127:0] r, bitv, t;
    r = '0;
    bitv = 128'd1 << 126;
    while (bitv != 0) begin
      t = r + bitv;
      if (v >= t) begin
        v = v - t;
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r[63:0];
  endfunction

  function automatic logic [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // expected new point for one input word
  function automatic point_t move_point(logic [31:0] c [3], logic [31:0] t [3],
                                        logic [31:0] s);
    logic signed [63:0] d [3];
    logic [63:0]        dm [3];
    logic [127:0]       l2, num, q;
    logic [63:0]        lf, sm;
    logic signed [63:0] sv, off;
    logic [31:0]        r [3];
    point_t             p;
    l2 = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = $signed({{32{t[i][31]}}, t[i]}) - $signed({{32{c[i][31]}}, c[i]});
      dm[i] = d[i] < 0 ? -d[i] : d[i];
      l2 += 128'(dm[i]) * 128'(dm[i]);
    end
    sv = $signed({{32{s[31]}}, s});
    if (l2 == 0 || (sv > 0 && l2 < 128'(sv) * 128'(sv))) begin
      p = '{t[0], t[1], t[2], 1'b1};
      return p;
    end
    lf = isqrt128(l2 << (2 * FRAC_BITS));
    sm = sv < 0 ? -sv : sv;
    for (int i = 0; i < 3; i++) begin
      num = (128'(dm[i]) * 128'(sm)) << FRAC_BITS;
      q = ((num + 128'(lf >> 1)) / 128'(lf)) & 128'hff_ffff_ffff;
      off = ((d[i] < 0) != (sv < 0)) ? -$signed(q[63:0]) : $signed(q[63:0]);
      r[i] = sat32($signed({{32{c[i][31]}}, c[i]}) + off);
    end
    p = '{r[0], r[1], r[2], 1'b0};
    return p;
  endfunction

  assign pending_o = moved_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] c [3];
    logic [31:0] t [3];
    point_t      exp_p;
    if (!rst_ni) begin
      moved_q.delete();
      errors_o <= 0;
      results_o <= 0;
      reached_cnt_o <= 0;
    end else begin
      // input word accepted: queue its prediction
      if (in_valid_i && !in_stall_i) begin
        c = '{cur_x_i, cur_y_i, cur_z_i};
        t = '{tgt_x_i, tgt_y_i, tgt_z_i};
        moved_q.push_back(move_point(c, t, step_dist_i));
      end
      // output word accepted: compare with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        results_o <= results_o + 1;
        if (reached_i) reached_cnt_o <= reached_cnt_o + 1;
        if (moved_q.size() == 0) begin
          $display("%0t: result with nothing expected: %h %h %h %b", $realtime,
                   res_x_i, res_y_i, res_z_i, reached_i);
          errors_o <= errors_o + 1;
        end else begin
          exp_p = moved_q.pop_front();
          if (exp_p != {res_x_i, res_y_i, res_z_i, reached_i}) begin
            $display("%0t: mismatch exp x=%h y=%h z=%h r=%b got x=%h y=%h z=%h r=%b",
                     $realtime, exp_p.x, exp_p.y, exp_p.z, exp_p.reached,
                     res_x_i, res_y_i, res_z_i, reached_i);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// tb_top: stimulus and verdict for vector_move_towards.
// Depends on vmt_pkg, vector_move_towards and vmt_checker.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM = 1500;
  localparam int DRAIN_CYCLES = 120;
  localparam longint CYCLE_LIMIT = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_i = 1'b0;
  logic        stall_o, valid_o, reached_o;
  logic [31:0] cur_x_i = '0, cur_y_i = '0, cur_z_i = '0;
  logic [31:0] tgt_x_i = '0, tgt_y_i = '0, tgt_z_i = '0, step_dist_i = '0;
  logic [31:0] res_x_o, res_y_o, res_z_o;
  int          errors, pending, results, reached_cnt;
  bit          calm = 1'b0;
  longint      cycles = 0;

  always #4 clk_i = ~clk_i;

  vector_move_towards DUT (.*);

  vmt_checker #(.FRAC_BITS(vmt_pkg::FRAC_BITS_DEF)) u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(valid_i), .in_stall_i(stall_o),
    .cur_x_i, .cur_y_i, .cur_z_i, .tgt_x_i, .tgt_y_i, .tgt_z_i, .step_dist_i,
    .out_valid_i(valid_o), .out_stall_i(stall_i),
    .res_x_i(res_x_o), .res_y_i(res_y_o), .res_z_i(res_z_o), .reached_i(reached_o),
    .errors_o(errors), .pending_o(pending), .results_o(results),
    .reached_cnt_o(reached_cnt)
  );

  // receiver stalls at random, except in calm stretches
  always @(negedge clk_i) stall_i <= !calm && $urandom_range(99) < 22;

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // present one word and hold it until accepted; valid stays high afterwards
  // so the next word can follow directly, the caller drops it when done
  task automatic send_word(logic [31:0] cx, cy, cz, tx, ty, tz, s);
    while (!calm && $urandom_range(99) < 22) begin
      valid_i <= 1'b0;
      @(negedge clk_i);
    end
    valid_i <= 1'b1;
    {cur_x_i, cur_y_i, cur_z_i} <= {cx, cy, cz};
    {tgt_x_i, tgt_y_i, tgt_z_i, step_dist_i} <= {tx, ty, tz, s};
    do @(posedge clk_i); while (stall_o);
    @(negedge clk_i);
  endtask

  // random coordinate: mostly small, sometimes full range or extreme
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      2, 3: return 32'($signed($urandom_range(2000000)) - 1000000) <<< 8;
      default: return 32'($signed($urandom_range(200000)) - 100000) <<< 4;
    endcase
  endfunction

  initial begin
    logic [31:0] cx, cy, cz, s;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: zero difference, overshoot, zero step, extremes, saturation
    send_word(0, 0, 0, 0, 0, 0, 0);
    send_word(32'h10000, 5, 6, 32'h10000, 5, 6, 32'h80000000);
    send_word(0, 0, 0, 32'h30000, 32'h40000, 0, 32'h10000);
    send_word(0, 0, 0, 32'h30000, 32'h40000, 0, 32'h50000);
    send_word(0, 0, 0, 32'h30000, 32'h40000, 0, 32'h60000);
    send_word(1, 2, 3, 32'h30000, 32'h40000, 0, 0);
    send_word(0, 0, 0, 32'h30000, 0, 0, 32'hffff0000);
    send_word(32'h80000000, 32'h80000000, 32'h80000000,
              32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_word(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
              32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff);
    send_word(32'h7fff0000, 0, 0, 32'h7ffe0000, 0, 0, 32'h80000000);
    send_word(32'h80000000, 32'h80000000, 0, 32'h80000001, 32'h80000001, 0,
              32'h80000000);
    send_word(32'hffffffff, 0, 0, 0, 0, 1, 1);
    send_word(0, 0, 0, 0, 0, 1, 32'hffffffff);
    send_word(32'h12345678, 32'hedcba987, 32'h0f0f0f0f,
              32'hf0f0f0f0, 32'h55555555, 32'haaaaaaaa, 32'h00010000);
    valid_i <= 1'b0;

    // hold off until the pipeline has drained
    while (pending != 0) @(negedge clk_i);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      calm = (i >= 600 && i < 800);
      cx = rand_coord(); cy = rand_coord(); cz = rand_coord();
      case ($urandom_range(9))
        0: s = $urandom();
        1: s = 32'h80000000;
        2: s = 0;
        default: s = 32'($signed($urandom_range(400000)) - 100000) <<< 4;
      endcase
      if ($urandom_range(19) == 0)
        send_word(cx, cy, cz, cx, cy, cz, s);
      else
        send_word(cx, cy, cz, rand_coord(), rand_coord(), rand_coord(), s);
    end
    valid_i <= 1'b0;
    calm = 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("Checked %0d results (%0d reached target) over directed extremes and",
             results, reached_cnt);
    $display("random points with random sender gaps and receiver stalls.");
    if (errors == 0 && pending == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
hw/rtl/vmt_pkg.sv
hw/rtl/vmt_sqrt_cell.sv
hw/rtl/vmt_div_cell.sv
hw/rtl/vector_move_towards.sv
tb/vmt_checker.sv
tb/tb_top.sv
